[src/ptcp_pkg.sv]
// ----------------------------------------------------------------------------
// ptcp_pkg
// Shared constants for the point-triangle closest point pipeline: default
// widths, register map and region codes.
// ----------------------------------------------------------------------------
package ptcp_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;

	localparam int TOL_WIDTH    = 24;
	localparam int DATA_WIDTH   = 32;
	localparam int ADDR_WIDTH   = 3;
	localparam int DIST_WIDTH   = 63;
	localparam int REGION_WIDTH = 3;

	localparam logic [TOL_WIDTH-1:0] TOL_RESET = 24'd1311;
	localparam logic [ADDR_WIDTH-3:0] TOL_INDEX = '0;

	localparam logic [REGION_WIDTH-1:0] RGN_A     = 3'd0;
	localparam logic [REGION_WIDTH-1:0] RGN_B     = 3'd1;
	localparam logic [REGION_WIDTH-1:0] RGN_AB    = 3'd2;
	localparam logic [REGION_WIDTH-1:0] RGN_C     = 3'd3;
	localparam logic [REGION_WIDTH-1:0] RGN_AC    = 3'd4;
	localparam logic [REGION_WIDTH-1:0] RGN_BC    = 3'd5;
	localparam logic [REGION_WIDTH-1:0] RGN_FACE  = 3'd6;
	localparam logic [REGION_WIDTH-1:0] RGN_DEGEN = 3'd7;

endpackage

[src/point_triangle_closest_point.sv]
// ----------------------------------------------------------------------------
// point_triangle_closest_point
// Closest point on a triangle to a query point by Voronoi region, with
// squared distance and a tolerance contact flag.
// ----------------------------------------------------------------------------
// Pipeline: 11 setup stages, COORD_WIDTH + 3 restoring divider stages,
// 4 distance stages.
// Throughput: one request per cycle; the whole pipe holds while a finished
// result is stalled.
// Reset: valid bits clear, tolerance returns to 1311 (0.02 in Q8.16).
// ----------------------------------------------------------------------------
module point_triangle_closest_point #(
	parameter int COORD_WIDTH = ptcp_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = ptcp_pkg::FRAC_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [ptcp_pkg::ADDR_WIDTH-1:0]        paddr,
	input  logic [ptcp_pkg::DATA_WIDTH-1:0]        pwdata,
	output logic [ptcp_pkg::DATA_WIDTH-1:0]        prdata,
	output logic                                   pready,
	input  logic                                   req_valid,
	output logic                                   req_stall,
	input  logic signed [COORD_WIDTH-1:0]          point_x,
	input  logic signed [COORD_WIDTH-1:0]          point_y,
	input  logic signed [COORD_WIDTH-1:0]          point_z,
	input  logic signed [COORD_WIDTH-1:0]          vert_a_x,
	input  logic signed [COORD_WIDTH-1:0]          vert_a_y,
	input  logic signed [COORD_WIDTH-1:0]          vert_a_z,
	input  logic signed [COORD_WIDTH-1:0]          vert_b_x,
	input  logic signed [COORD_WIDTH-1:0]          vert_b_y,
	input  logic signed [COORD_WIDTH-1:0]          vert_b_z,
	input  logic signed [COORD_WIDTH-1:0]          vert_c_x,
	input  logic signed [COORD_WIDTH-1:0]          vert_c_y,
	input  logic signed [COORD_WIDTH-1:0]          vert_c_z,
	output logic                                   rsp_valid,
	input  logic                                   rsp_stall,
	output logic signed [COORD_WIDTH-1:0]          closest_x,
	output logic signed [COORD_WIDTH-1:0]          closest_y,
	output logic signed [COORD_WIDTH-1:0]          closest_z,
	output logic [ptcp_pkg::REGION_WIDTH-1:0]      region,
	output logic [ptcp_pkg::DIST_WIDTH-1:0]        dist_squared,
	output logic                                   near_flag
);

	localparam int W    = COORD_WIDTH;
	localparam int DW   = W + 1;
	localparam int PW   = 2 * DW;
	localparam int DOTW = PW + 2;
	localparam int H    = DOTW / 2;
	localparam int HH   = DOTW - H;
	localparam int PPW  = DOTW + 2;
	localparam int VPW  = 2 * DOTW;
	localparam int VW   = VPW + 1;
	localparam int DENW = VW + 2;
	localparam int CK   = (VW + 3) / 4;
	localparam int TW   = VW - 3 * CK;
	localparam int NPW  = DW + CK + 1;
	localparam int NUMW = DW + VW + 1;
	localparam int RW   = NUMW + 2;
	localparam int QB   = W + 3;
	localparam int XW   = DENW + 1 + QB;
	localparam int SSW  = PW + 2;
	localparam int SHL  = (2 * FRAC_BITS < 32) ? 32 - 2 * FRAC_BITS : 0;
	localparam int SHR  = (2 * FRAC_BITS > 32) ? 2 * FRAC_BITS - 32 : 0;
	localparam int SW   = SSW + 32;
	localparam int TSW  = 2 * ptcp_pkg::TOL_WIDTH;

	localparam logic signed [W-1:0] CHI = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] CLO = {1'b1, {(W-1){1'b0}}};
	localparam logic [SW-1:0] DMAX = SW'({ptcp_pkg::DIST_WIDTH{1'b1}});

	typedef struct packed {
		logic [2:0][W-1:0]  p;
		logic [2:0][W-1:0]  a;
		logic [2:0][W-1:0]  b;
		logic [2:0][W-1:0]  c;
		logic [2:0][DW-1:0] ab;
		logic [2:0][DW-1:0] ac;
		logic [2:0][DW-1:0] bc;
	} geo_t;

	typedef struct packed {
		logic [2:0][W-1:0]                  pt;
		logic [2:0][W-1:0]                  st;
		logic                               vtx;
		logic [ptcp_pkg::REGION_WIDTH-1:0]  rgn;
	} tail_t;

	typedef struct packed {
		logic [2:0][XW-1:0] rem;
		logic [2:0][QB-1:0] quo;
		logic [DENW:0]      dd;
		logic [2:0]         neg;
		logic [2:0]         ovf;
		tail_t              tl;
	} dv_t;

	// configuration
	logic [ptcp_pkg::TOL_WIDTH-1:0] tol_q;
	logic [TSW-1:0]                 tsq;

	assign pready = 1'b1;
	assign prdata = ptcp_pkg::DATA_WIDTH'(tol_q);
	assign tsq    = TSW'(tol_q) * TSW'(tol_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= ptcp_pkg::TOL_RESET;
		end else if (psel && penable && pwrite
				&& paddr[ptcp_pkg::ADDR_WIDTH-1:2] == ptcp_pkg::TOL_INDEX) begin
			tol_q <= pwdata[ptcp_pkg::TOL_WIDTH-1:0];
		end
	end

	// flow control
	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11;
	logic v_dv [QB];
	logic v_s12, v_s13, v_s14, v_s15;

	assign en        = !v_s15 || !rsp_stall;
	assign req_stall = !en;
	assign rsp_valid = v_s15;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
			v_s9 <= 1'b0; v_s10 <= 1'b0; v_s11 <= 1'b0;
			for (int j = 0; j < QB; j++) v_dv[j] <= 1'b0;
			v_s12 <= 1'b0; v_s13 <= 1'b0; v_s14 <= 1'b0; v_s15 <= 1'b0;
		end else if (en) begin
			v_s1 <= req_valid; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			v_s5 <= v_s4; v_s6 <= v_s5; v_s7 <= v_s6; v_s8 <= v_s7;
			v_s9 <= v_s8; v_s10 <= v_s9; v_s11 <= v_s10;
			v_dv[0] <= v_s11;
			for (int j = 1; j < QB; j++) v_dv[j] <= v_dv[j-1];
			v_s12 <= v_dv[QB-1]; v_s13 <= v_s12; v_s14 <= v_s13; v_s15 <= v_s14;
		end
	end

	// stage 1: edge and offset vectors
	logic signed [W-1:0] pin [3];
	logic signed [W-1:0] ain [3];
	logic signed [W-1:0] bin [3];
	logic signed [W-1:0] cin [3];

	assign pin[0] = point_x;  assign pin[1] = point_y;  assign pin[2] = point_z;
	assign ain[0] = vert_a_x; assign ain[1] = vert_a_y; assign ain[2] = vert_a_z;
	assign bin[0] = vert_b_x; assign bin[1] = vert_b_y; assign bin[2] = vert_b_z;
	assign cin[0] = vert_c_x; assign cin[1] = vert_c_y; assign cin[2] = vert_c_z;

	geo_t geo_s1, geo_s2, geo_s3, geo_s4, geo_s5;
	logic signed [DW-1:0] ap_s1 [3];
	logic signed [DW-1:0] bp_s1 [3];
	logic signed [DW-1:0] cp_s1 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				geo_s1.p[i]  <= pin[i];
				geo_s1.a[i]  <= ain[i];
				geo_s1.b[i]  <= bin[i];
				geo_s1.c[i]  <= cin[i];
				geo_s1.ab[i] <= bin[i] - ain[i];
				geo_s1.ac[i] <= cin[i] - ain[i];
				geo_s1.bc[i] <= cin[i] - bin[i];
				ap_s1[i]     <= pin[i] - ain[i];
				bp_s1[i]     <= pin[i] - bin[i];
				cp_s1[i]     <= pin[i] - cin[i];
			end
		end
	end

	// stage 2: dot product terms
	logic signed [PW-1:0] pr_s2 [6][3];

	always_ff @(posedge clk) begin
		if (en) begin
			geo_s2 <= geo_s1;
			for (int i = 0; i < 3; i++) begin
				pr_s2[0][i] <= $signed(geo_s1.ab[i]) * ap_s1[i];
				pr_s2[1][i] <= $signed(geo_s1.ac[i]) * ap_s1[i];
				pr_s2[2][i] <= $signed(geo_s1.ab[i]) * bp_s1[i];
				pr_s2[3][i] <= $signed(geo_s1.ac[i]) * bp_s1[i];
				pr_s2[4][i] <= $signed(geo_s1.ab[i]) * cp_s1[i];
				pr_s2[5][i] <= $signed(geo_s1.ac[i]) * cp_s1[i];
			end
		end
	end

	// stage 3: d1..d6
	logic signed [DOTW-1:0] d_s3 [6];

	always_ff @(posedge clk) begin
		if (en) begin
			geo_s3 <= geo_s2;
			for (int k = 0; k < 6; k++) d_s3[k] <= pr_s2[k][0] + pr_s2[k][1] + pr_s2[k][2];
		end
	end

	// stage 4: partial products of the barycentric cross terms
	logic signed [DOTW-1:0] px [6];
	logic signed [DOTW-1:0] py [6];
	logic signed [HH-1:0]   xh [6];
	logic signed [HH-1:0]   yh [6];
	logic signed [H:0]      xl [6];
	logic signed [H:0]      yl [6];
	logic signed [PPW-1:0]  pp_c [6][4];
	logic signed [PPW-1:0]  pp_s4 [6][4];
	logic signed [DOTW-1:0] d_s4 [6];

	assign px[0] = d_s3[0]; assign py[0] = d_s3[3];
	assign px[1] = d_s3[2]; assign py[1] = d_s3[1];
	assign px[2] = d_s3[4]; assign py[2] = d_s3[1];
	assign px[3] = d_s3[0]; assign py[3] = d_s3[5];
	assign px[4] = d_s3[2]; assign py[4] = d_s3[5];
	assign px[5] = d_s3[4]; assign py[5] = d_s3[3];

	always_comb begin
		for (int j = 0; j < 6; j++) begin
			xh[j] = $signed(px[j][DOTW-1:H]);
			yh[j] = $signed(py[j][DOTW-1:H]);
			xl[j] = $signed({1'b0, px[j][H-1:0]});
			yl[j] = $signed({1'b0, py[j][H-1:0]});
			pp_c[j][0] = xh[j] * yh[j];
			pp_c[j][1] = xh[j] * yl[j];
			pp_c[j][2] = xl[j] * yh[j];
			pp_c[j][3] = xl[j] * yl[j];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			geo_s4 <= geo_s3;
			d_s4   <= d_s3;
			pp_s4  <= pp_c;
		end
	end

	// stage 5: va, vb, vc
	logic signed [VPW-1:0] prod_c [6];
	logic signed [VW-1:0]  va_s5, vb_s5, vc_s5;
	logic signed [DOTW-1:0] d_s5 [6];

	always_comb begin
		for (int j = 0; j < 6; j++) begin
			prod_c[j] = (pp_s4[j][0] <<< (2 * H)) + ((pp_s4[j][1] + pp_s4[j][2]) <<< H)
				+ pp_s4[j][3];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			geo_s5 <= geo_s4;
			d_s5   <= d_s4;
			vc_s5  <= prod_c[0] - prod_c[1];
			vb_s5  <= prod_c[2] - prod_c[3];
			va_s5  <= prod_c[4] - prod_c[5];
		end
	end

	// stage 6: region select
	logic signed [DOTW:0]   t43, t56, den_e1, den_e2;
	logic signed [DENW-1:0] den_c;
	logic signed [VW-1:0]   m_c [2];
	logic signed [DW-1:0]   dir_c [2][3];
	logic [2:0][W-1:0]      st_c;
	logic                   vtx_c;
	logic [ptcp_pkg::REGION_WIDTH-1:0] rgn_c;

	always_comb begin
		t43    = d_s5[3] - d_s5[2];
		t56    = d_s5[4] - d_s5[5];
		den_e1 = d_s5[0] - d_s5[2];
		den_e2 = d_s5[1] - d_s5[5];
		den_c  = DENW'(1);
		m_c[0] = '0;
		m_c[1] = '0;
		for (int i = 0; i < 3; i++) begin
			dir_c[0][i] = $signed(geo_s5.ab[i]);
			dir_c[1][i] = $signed(geo_s5.ac[i]);
		end
		st_c  = geo_s5.a;
		vtx_c = 1'b1;
		rgn_c = ptcp_pkg::RGN_A;
		if (d_s5[0] <= 0 && d_s5[1] <= 0) begin
			rgn_c = ptcp_pkg::RGN_A;
		end else if (d_s5[2] >= 0 && d_s5[3] <= d_s5[2]) begin
			rgn_c = ptcp_pkg::RGN_B;
			st_c  = geo_s5.b;
		end else if (vc_s5 <= 0 && d_s5[0] >= 0 && d_s5[2] <= 0) begin
			if (den_e1 == 0) begin
				rgn_c = ptcp_pkg::RGN_DEGEN;
			end else begin
				rgn_c  = ptcp_pkg::RGN_AB;
				vtx_c  = 1'b0;
				den_c  = den_e1;
				m_c[0] = d_s5[0];
			end
		end else if (d_s5[5] >= 0 && d_s5[4] <= d_s5[5]) begin
			rgn_c = ptcp_pkg::RGN_C;
			st_c  = geo_s5.c;
		end else if (vb_s5 <= 0 && d_s5[1] >= 0 && d_s5[5] <= 0) begin
			if (den_e2 == 0) begin
				rgn_c = ptcp_pkg::RGN_DEGEN;
			end else begin
				rgn_c  = ptcp_pkg::RGN_AC;
				vtx_c  = 1'b0;
				den_c  = den_e2;
				m_c[0] = d_s5[1];
				for (int i = 0; i < 3; i++) dir_c[0][i] = $signed(geo_s5.ac[i]);
			end
		end else if (va_s5 <= 0 && t43 >= 0 && t56 >= 0) begin
			if (t43 + t56 == 0) begin
				rgn_c = ptcp_pkg::RGN_DEGEN;
			end else begin
				rgn_c  = ptcp_pkg::RGN_BC;
				vtx_c  = 1'b0;
				den_c  = t43 + t56;
				m_c[0] = t43;
				st_c   = geo_s5.b;
				for (int i = 0; i < 3; i++) dir_c[0][i] = $signed(geo_s5.bc[i]);
			end
		end else if (va_s5 + vb_s5 + vc_s5 == 0) begin
			rgn_c = ptcp_pkg::RGN_DEGEN;
		end else begin
			rgn_c  = ptcp_pkg::RGN_FACE;
			vtx_c  = 1'b0;
			den_c  = va_s5 + vb_s5 + vc_s5;
			m_c[0] = vb_s5;
			m_c[1] = vc_s5;
		end
	end

	logic signed [DENW-1:0] den_s6, den_s7, den_s8;
	logic signed [VW-1:0]   m_s6 [2];
	logic signed [DW-1:0]   dir_s6 [2][3];
	tail_t tail_s6, tail_s7, tail_s8, tail_s9, tail_s10;

	always_ff @(posedge clk) begin
		if (en) begin
			den_s6      <= den_c;
			m_s6        <= m_c;
			dir_s6      <= dir_c;
			tail_s6.pt  <= geo_s5.p;
			tail_s6.st  <= st_c;
			tail_s6.vtx <= vtx_c;
			tail_s6.rgn <= rgn_c;
		end
	end

	// stage 7: numerator partial products
	logic signed [CK:0]    mc [2][3];
	logic signed [TW-1:0]  mt [2];
	logic signed [NPW-1:0] pn_c [3][2][4];
	logic signed [NPW-1:0] pn_s7 [3][2][4];

	always_comb begin
		for (int s = 0; s < 2; s++) begin
			for (int k = 0; k < 3; k++) mc[s][k] = $signed({1'b0, m_s6[s][k*CK +: CK]});
			mt[s] = $signed(m_s6[s][VW-1:3*CK]);
		end
		for (int i = 0; i < 3; i++) begin
			for (int s = 0; s < 2; s++) begin
				for (int k = 0; k < 3; k++) pn_c[i][s][k] = dir_s6[s][i] * mc[s][k];
				pn_c[i][s][3] = dir_s6[s][i] * mt[s];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pn_s7   <= pn_c;
			den_s7  <= den_s6;
			tail_s7 <= tail_s6;
		end
	end

	// stage 8: numerators
	logic signed [NUMW-1:0] num_c [3];
	logic signed [NUMW-1:0] num_s8 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			num_c[i] = '0;
			for (int s = 0; s < 2; s++) begin
				for (int k = 0; k < 4; k++) num_c[i] = num_c[i] + (pn_s7[i][s][k] <<< (k * CK));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s8  <= num_c;
			den_s8  <= den_s7;
			tail_s8 <= tail_s7;
		end
	end

	// stage 9: magnitudes and quotient signs
	logic [NUMW-1:0] nabs_s9 [3];
	logic [DENW-1:0] dabs_s9;
	logic [2:0]      neg_s9, neg_s10;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				nabs_s9[i] <= num_s8[i][NUMW-1] ? -num_s8[i] : num_s8[i];
				neg_s9[i]  <= num_s8[i][NUMW-1] ^ den_s8[DENW-1];
			end
			dabs_s9 <= den_s8[DENW-1] ? -den_s8 : den_s8;
			tail_s9 <= tail_s8;
		end
	end

	// stage 10: rounding offset, 2n + d over 2d
	logic [RW-1:0] n2_s10 [3];
	logic [DENW:0] d2_s10;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) n2_s10[i] <= RW'({nabs_s9[i], 1'b0}) + RW'(dabs_s9);
			d2_s10   <= {dabs_s9, 1'b0};
			neg_s10  <= neg_s9;
			tail_s10 <= tail_s9;
		end
	end

	// stage 11: quotient range check, divider load
	dv_t dv_s11;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dv_s11.rem[i] <= XW'(n2_s10[i]);
				dv_s11.quo[i] <= '0;
				dv_s11.ovf[i] <= XW'(n2_s10[i]) >= (XW'(d2_s10) << QB);
			end
			dv_s11.dd  <= d2_s10;
			dv_s11.neg <= neg_s10;
			dv_s11.tl  <= tail_s10;
		end
	end

	// restoring divider, one quotient bit per stage
	dv_t dv_in [QB];
	dv_t dv_c  [QB];
	dv_t dv_s  [QB];

	always_comb begin
		for (int j = 0; j < QB; j++) begin
			dv_in[j] = (j == 0) ? dv_s11 : dv_s[(j == 0) ? 0 : j-1];
			dv_c[j]  = dv_in[j];
			for (int i = 0; i < 3; i++) begin
				if (dv_in[j].rem[i] >= (XW'(dv_in[j].dd) << (QB - 1 - j))) begin
					dv_c[j].rem[i] = dv_in[j].rem[i] - (XW'(dv_in[j].dd) << (QB - 1 - j));
					dv_c[j].quo[i][QB-1-j] = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < QB; j++) dv_s[j] <= dv_c[j];
		end
	end

	// stage 12: signed quotient, offset and clamp
	logic [QB-1:0]        qm_c [3];
	logic signed [QB+1:0] qs_c [3];
	logic signed [QB+1:0] tot_c [3];
	logic signed [W-1:0]  qq_c [3];
	logic signed [W-1:0]  qq_s12 [3];
	logic signed [W-1:0]  qq_s13 [3], qq_s14 [3];
	logic [2:0][W-1:0]    pt_s12;
	logic [ptcp_pkg::REGION_WIDTH-1:0] rgn_s12, rgn_s13, rgn_s14;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qm_c[i]  = dv_s[QB-1].ovf[i] ? {QB{1'b1}} : dv_s[QB-1].quo[i];
			qs_c[i]  = $signed({2'b00, qm_c[i]});
			if (dv_s[QB-1].neg[i]) qs_c[i] = -qs_c[i];
			tot_c[i] = qs_c[i] + $signed(dv_s[QB-1].tl.st[i]);
			if (dv_s[QB-1].tl.vtx) tot_c[i] = $signed(dv_s[QB-1].tl.st[i]);
			if (tot_c[i] > CHI) begin
				qq_c[i] = CHI;
			end else if (tot_c[i] < CLO) begin
				qq_c[i] = CLO;
			end else begin
				qq_c[i] = tot_c[i][W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qq_s12  <= qq_c;
			pt_s12  <= dv_s[QB-1].tl.pt;
			rgn_s12 <= dv_s[QB-1].tl.rgn;
		end
	end

	// stage 13: per-axis squares
	logic signed [DW-1:0] dp_c [3];
	logic signed [PW-1:0] sq_s13 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) dp_c[i] = $signed(pt_s12[i]) - qq_s12[i];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) sq_s13[i] <= dp_c[i] * dp_c[i];
			qq_s13  <= qq_s12;
			rgn_s13 <= rgn_s12;
		end
	end

	// stage 14: sum of squares
	logic [SSW-1:0] ss_s14;

	always_ff @(posedge clk) begin
		if (en) begin
			ss_s14  <= SSW'(sq_s13[0]) + SSW'(sq_s13[1]) + SSW'(sq_s13[2]);
			qq_s14  <= qq_s13;
			rgn_s14 <= rgn_s13;
		end
	end

	// stage 15: scale to Q31.32, saturate, tolerance compare
	logic [SW-1:0] scaled;

	assign scaled = (SW'(ss_s14) << SHL) >> SHR;

	always_ff @(posedge clk) begin
		if (en) begin
			closest_x    <= qq_s14[0];
			closest_y    <= qq_s14[1];
			closest_z    <= qq_s14[2];
			region       <= rgn_s14;
			dist_squared <= (scaled > DMAX) ? DMAX[ptcp_pkg::DIST_WIDTH-1:0]
				: scaled[ptcp_pkg::DIST_WIDTH-1:0];
			near_flag    <= scaled <= SW'(tsq);
		end
	end

endmodule
